>>> rtl/assert_macros.svh
// assertion helpers used by integer_to_radix_string
// no dependencies; each macro checks one property on a clock with active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/itrs_pkg.sv
// shared constants and the digit-to-ascii function for integer_to_radix_string
// no dependencies
package itrs_pkg;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
    localparam logic [CHAR_W-1:0]  MINUS_CHAR = 7'h2d;
    localparam logic [CHAR_W-1:0]  ZERO_CHAR  = 7'h30;
    localparam logic [CHAR_W-1:0]  ALPHA_CHAR = 7'h61;
    localparam logic [CHAR_W-1:0]  EMPTY_CHAR = 7'h00;

    typedef logic [RADIX_W-1:0] digit_t;
    typedef logic [CHAR_W-1:0]  char_t;

    // 0..9 map to '0'..'9', 10..35 to 'a'..'z'
    function automatic char_t digit_char(input digit_t d);
        char_t wide_d;
        wide_d = {1'b0, d};
        if (d < 6'd10) begin
            digit_char = ZERO_CHAR + wide_d;
        end else begin
            digit_char = ALPHA_CHAR + (wide_d - 7'd10);
        end
    endfunction

endpackage

>>> rtl/itrs_div.sv
// bit-serial restoring divider: one quotient bit per cycle, narrow remainder
// depends on itrs_pkg for the divisor width
module itrs_div #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [VALUE_WIDTH-1:0]      dividend,
    input  logic [itrs_pkg::RADIX_W-1:0] divisor,
    output logic                        done,
    output logic [VALUE_WIDTH-1:0]      quotient,
    output logic [itrs_pkg::RADIX_W-1:0] remainder
);
    import itrs_pkg::*;

    localparam int CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    logic [VALUE_WIDTH-1:0] q_reg, q_next;
    logic [RADIX_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic [RADIX_W:0] rem_shift;
    logic [RADIX_W:0] rem_diff;
    logic             ge;

    always_comb begin
        rem_shift = {rem_reg, q_reg[VALUE_WIDTH-1]};
        rem_diff  = rem_shift - {1'b0, divisor};
        ge        = (rem_shift >= {1'b0, divisor});

        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(VALUE_WIDTH - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits back in RADIX_W bits
            rem_next = ge ? rem_diff[RADIX_W-1:0] : rem_shift[RADIX_W-1:0];
            q_next   = {q_reg[VALUE_WIDTH-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/integer_to_radix_string.sv
// Converts one signed VALUE_WIDTH-bit integer per input transfer into ASCII text in the radix
// held in the radix register (written through cfg_we/cfg_wdata, reset 10), one character per
// output transfer, most significant first, with a leading '-' for negative values and m_last on
// the final character. A radix outside 2..36 gives one output with m_empty_res set and
// m_character 0. Items are handled one at a time: each digit comes from a bit-serial divider
// (itrs_div), all digits are found before the first character goes out, and an output stall
// holds the item in emission.
// Depends on itrs_pkg, itrs_div and assert_macros.svh.
`include "assert_macros.svh"

module integer_to_radix_string #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [itrs_pkg::RADIX_W-1:0]  cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_WIDTH-1:0] s_number,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [itrs_pkg::CHAR_W-1:0]   m_character,
    output logic                          m_last,
    output logic                          m_empty_res
);
    import itrs_pkg::*;

    localparam int IDX_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    state_t             state_reg, state_next;
    logic [RADIX_W-1:0] radix_reg;
    logic               neg_reg, neg_next;
    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               m_valid_reg, m_valid_next;
    char_t              m_character_reg, m_character_next;
    logic               m_last_reg, m_last_next;
    logic               m_empty_reg, m_empty_next;

    digit_t digit_store [VALUE_WIDTH];

    logic                   slot_free;
    logic                   radix_bad;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quotient;
    digit_t                 div_remainder;

    itrs_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (radix_reg),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign slot_free = !m_valid_reg || m_ready;
    assign radix_bad = (radix_reg < RADIX_MIN) || (radix_reg > RADIX_MAX);
    // unsigned magnitude, so the most negative value comes out right
    assign magnitude = s_number[VALUE_WIDTH-1] ? (~s_number + 1'b1) : s_number;
    assign div_dividend = (state_reg == ST_IDLE) ? magnitude : div_quotient;

    always_comb begin
        state_next       = state_reg;
        neg_next         = neg_reg;
        wr_idx_next      = wr_idx_reg;
        rd_idx_next      = rd_idx_reg;
        m_valid_next     = m_valid_reg;
        m_character_next = m_character_reg;
        m_last_next      = m_last_reg;
        m_empty_next     = m_empty_reg;
        div_start        = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (radix_bad) begin
                        state_next = ST_EMPTY;
                    end else begin
                        neg_next    = s_number[VALUE_WIDTH-1];
                        wr_idx_next = '0;
                        div_start   = 1'b1;
                        state_next  = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (div_quotient != '0) begin
                        wr_idx_next = wr_idx_reg + 1'b1;
                        div_start   = 1'b1;
                    end else begin
                        rd_idx_next = wr_idx_reg;
                        state_next  = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_empty_next = 1'b0;
                    if (neg_reg) begin
                        m_character_next = MINUS_CHAR;
                        m_last_next      = 1'b0;
                        neg_next         = 1'b0;
                    end else begin
                        m_character_next = digit_char(digit_store[rd_idx_reg]);
                        m_last_next      = (rd_idx_reg == '0);
                        if (rd_idx_reg == '0) begin
                            state_next = ST_IDLE;
                        end else begin
                            rd_idx_next = rd_idx_reg - 1'b1;
                        end
                    end
                end
            end
            ST_EMPTY: begin
                if (slot_free) begin
                    m_valid_next     = 1'b1;
                    m_character_next = EMPTY_CHAR;
                    m_last_next      = 1'b1;
                    m_empty_next     = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            radix_reg   <= 6'd10;
            neg_reg     <= 1'b0;
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            neg_reg     <= neg_next;
            wr_idx_reg  <= wr_idx_next;
            rd_idx_reg  <= rd_idx_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                radix_reg <= cfg_wdata;
            end
        end
        m_character_reg <= m_character_next;
        m_last_reg      <= m_last_next;
        m_empty_reg     <= m_empty_next;
    end

    // digits land least significant first
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIV && div_done) begin
            digit_store[wr_idx_reg] <= div_remainder;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;
    assign m_empty_res = m_empty_reg;

    `ASSERT_IMPL(a_empty_shape, aclk, aresetn, m_valid && m_empty_res, m_last && (m_character == EMPTY_CHAR))
    `ASSERT_IMPL(a_text_nonzero, aclk, aresetn, m_valid && !m_empty_res, m_character != EMPTY_CHAR)
    `ASSERT_IMPL(a_div_done_state, aclk, aresetn, div_done, state_reg == ST_DIV)
    `ASSERT_NEXT(a_bad_radix, aclk, aresetn, s_valid && s_ready && radix_bad, state_reg == ST_EMPTY)

endmodule
